[design/ragmc_pkg.sv]
// constants, state codes and helpers for the rectangle-add grid block
// no dependencies; used by rect_add_grid_max_count
`timescale 1ns / 1ps

package ragmc_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int DEPTH     = MAX_ROWS * MAX_COLS;
    localparam int ROW_W     = ($clog2(MAX_ROWS) > 0) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W     = ($clog2(MAX_COLS) > 0) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W    = ($clog2(DEPTH) > 0) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W   = $clog2(DEPTH + 1);
    localparam int SIZE_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int VALUE_W   = 64;
    localparam int AMOUNT_W  = 32;
    localparam int OCOUNT_W  = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = CFG_IDX_W'(1);

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ADD,
        ST_W_RD,
        ST_W_SUM,
        ST_W_COL,
        ST_W_CMP,
        ST_W_OUT
    } state_t;

    // zero is taken as one, anything above the maximum saturates
    function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v, int maxv);
        logic [SIZE_W-1:0] s;
        s = v;
        if (s == '0) begin
            s = SIZE_W'(1);
        end
        if (32'(s) > maxv) begin
            s = SIZE_W'(maxv);
        end
        return s;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] row,
                                                    logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
        return a;
    endfunction

endpackage

[design/rect_add_grid_max_count.sv]
// rectangle-add grid with max report: 2d difference array in one grid memory,
// prefix sum walk with a column buffer and one shared 64-bit adder
// depends on ragmc_pkg
`timescale 1ns / 1ps

// Accumulates signed amounts over inclusive one-based rectangles of a grid of
// 64-bit wrapping sums and, on a finish word, reports the largest cell value and
// how many cells hold it, then starts the next batch from an all-zero grid.
// An add word that is valid is followed, after its acceptance, by four corner
// read-modify-writes on the grid memory's one read port and one write port, with
// the read of one corner overlapped with the write of the one before, and one more
// step for the last write. An add word that is ignored (zero amount, bad rectangle)
// leaves the block idle. A finish word walks every grid entry once, zeroing it as
// it goes: each cell inside the configured size passes through read, row sum,
// column sum and compare, the two sums through the one shared adder, and each other
// entry through the read step alone; the result register is then loaded, which
// also waits while an earlier result is still held.
// After reset a clearing pass over all 4096 entries runs before the first word is taken;
// configuration writes are taken at any time but belong in idle periods.
module rect_add_grid_max_count (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ragmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ragmc_pkg::SIZE_W-1:0]        cfg_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_action,
    input  logic [6:0]                          s_row_first,
    input  logic [6:0]                          s_col_first,
    input  logic [6:0]                          s_row_last,
    input  logic [6:0]                          s_col_last,
    input  logic signed [ragmc_pkg::AMOUNT_W-1:0] s_amount,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ragmc_pkg::VALUE_W-1:0] m_max_value,
    output logic [ragmc_pkg::OCOUNT_W-1:0]      m_max_count
);

    localparam int VW = ragmc_pkg::VALUE_W;

    ragmc_pkg::state_t state_reg, state_next;

    logic [ragmc_pkg::SIZE_W-1:0]  grid_rows_reg, grid_cols_reg;
    logic [2:0]                    phase_reg, phase_next;
    logic [6:0]                    r1_reg, c1_reg, r2_reg, c2_reg;
    logic [ragmc_pkg::AMOUNT_W-1:0] amt_reg;
    logic [ragmc_pkg::ADDR_W-1:0]  wr_addr_reg, wr_addr_next;
    logic                          wr_neg_reg, wr_neg_next;
    logic                          wr_keep_reg, wr_keep_next;
    logic [ragmc_pkg::ROW_W-1:0]   walk_row_reg, walk_row_next;
    logic [ragmc_pkg::COL_W-1:0]   walk_col_reg, walk_col_next;
    logic [VW-1:0]                 rowacc_reg, rowacc_next;
    logic [VW-1:0]                 val_reg, val_next;
    logic [VW-1:0]                 best_reg, best_next;
    logic [ragmc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                          first_reg, first_next;
    logic                          m_valid_reg, m_valid_next;
    logic [VW-1:0]                 out_value_reg, out_value_next;
    logic [ragmc_pkg::OCOUNT_W-1:0] out_count_reg, out_count_next;

    // grid memory and column buffer
    logic [VW-1:0] grid_mem [ragmc_pkg::DEPTH];
    logic [VW-1:0] col_mem  [ragmc_pkg::MAX_COLS];
    logic [VW-1:0] grid_rd_reg, col_rd_reg;
    logic                          mem_we;
    logic [ragmc_pkg::ADDR_W-1:0]  mem_wa, mem_ra;
    logic [VW-1:0]                 mem_wd;
    logic                          col_we;

    // shared adder
    logic [VW-1:0] add_a, add_b, add_sum;
    logic          add_cin;

    logic                          s_accept;
    logic                          rect_ok;
    logic [7:0]                    corner_row, corner_col;
    logic                          corner_keep;
    logic [ragmc_pkg::ADDR_W-1:0]  corner_addr, cur_addr;
    logic                          in_size, walk_last;
    logic [VW-1:0]                 amt_ext;

    assign s_ready   = (state_reg == ragmc_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_accept  = s_valid && s_ready;

    assign m_valid     = m_valid_reg;
    assign m_max_value = out_value_reg;
    assign m_max_count = out_count_reg;

    assign rect_ok = (s_amount != '0) && (s_row_first != '0) && (s_col_first != '0)
                  && (s_row_first <= s_row_last) && (s_col_first <= s_col_last)
                  && (s_row_last <= grid_rows_reg) && (s_col_last <= grid_cols_reg);

    // corner order: (r1,c1) +, (r1,c2+1) -, (r2+1,c1) -, (r2+1,c2+1) +
    assign corner_row  = phase_reg[1] ? ({1'b0, r2_reg} + 8'd1) : {1'b0, r1_reg};
    assign corner_col  = phase_reg[0] ? ({1'b0, c2_reg} + 8'd1) : {1'b0, c1_reg};
    assign corner_keep = (corner_row <= {1'b0, grid_rows_reg})
                      && (corner_col <= {1'b0, grid_cols_reg});
    assign corner_addr = ragmc_pkg::cell_addr(ragmc_pkg::ROW_W'(corner_row - 8'd1),
                                              ragmc_pkg::COL_W'(corner_col - 8'd1));

    assign cur_addr  = ragmc_pkg::cell_addr(walk_row_reg, walk_col_reg);
    assign in_size   = (32'(walk_row_reg) < 32'(grid_rows_reg))
                    && (32'(walk_col_reg) < 32'(grid_cols_reg));
    assign walk_last = (walk_row_reg == ragmc_pkg::ROW_W'(ragmc_pkg::MAX_ROWS - 1))
                    && (walk_col_reg == ragmc_pkg::COL_W'(ragmc_pkg::MAX_COLS - 1));

    assign amt_ext = {{(VW - ragmc_pkg::AMOUNT_W){amt_reg[ragmc_pkg::AMOUNT_W-1]}}, amt_reg};
    assign add_sum = add_a + add_b + VW'(add_cin);

    always_comb begin
        add_a   = grid_rd_reg;
        add_b   = wr_neg_reg ? ~amt_ext : amt_ext;
        add_cin = wr_neg_reg;
        unique case (state_reg)
            ragmc_pkg::ST_W_SUM: begin
                add_a   = (walk_col_reg == '0) ? '0 : rowacc_reg;
                add_b   = grid_rd_reg;
                add_cin = 1'b0;
            end
            ragmc_pkg::ST_W_COL: begin
                add_a   = rowacc_reg;
                add_b   = (walk_row_reg == '0) ? '0 : col_rd_reg;
                add_cin = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        wr_addr_next   = wr_addr_reg;
        wr_neg_next    = wr_neg_reg;
        wr_keep_next   = wr_keep_reg;
        walk_row_next  = walk_row_reg;
        walk_col_next  = walk_col_reg;
        rowacc_next    = rowacc_reg;
        val_next       = val_reg;
        best_next      = best_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        out_value_next = out_value_reg;
        out_count_next = out_count_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        mem_we         = 1'b0;
        mem_wa         = cur_addr;
        mem_ra         = cur_addr;
        mem_wd         = '0;
        col_we         = 1'b0;

        unique case (state_reg)
            ragmc_pkg::ST_IDLE: begin
                if (s_accept) begin
                    walk_row_next = '0;
                    walk_col_next = '0;
                    phase_next    = '0;
                    first_next    = 1'b1;
                    if (s_action == ragmc_pkg::ACT_FINISH) begin
                        state_next = ragmc_pkg::ST_W_RD;
                    end else if (rect_ok) begin
                        state_next = ragmc_pkg::ST_ADD;
                    end
                end
            end
            ragmc_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                walk_col_next = walk_col_reg + ragmc_pkg::COL_W'(1);
                if (walk_col_reg == ragmc_pkg::COL_W'(ragmc_pkg::MAX_COLS - 1)) begin
                    walk_col_next = '0;
                    walk_row_next = walk_row_reg + ragmc_pkg::ROW_W'(1);
                end
                if (walk_last) begin
                    state_next = ragmc_pkg::ST_IDLE;
                end
            end
            ragmc_pkg::ST_ADD: begin
                // read of this corner overlaps write of the previous one
                mem_ra = corner_addr;
                mem_wa = wr_addr_reg;
                mem_wd = add_sum;
                mem_we = (phase_reg != '0) && wr_keep_reg;
                wr_addr_next = corner_addr;
                wr_neg_next  = phase_reg[0] ^ phase_reg[1];
                wr_keep_next = corner_keep;
                phase_next   = phase_reg + 3'd1;
                if (phase_reg == 3'd4) begin
                    state_next = ragmc_pkg::ST_IDLE;
                end
            end
            ragmc_pkg::ST_W_RD: begin
                // zero the entry while reading its old value
                mem_we = 1'b1;
                if (in_size) begin
                    state_next = ragmc_pkg::ST_W_SUM;
                end else begin
                    walk_col_next = walk_col_reg + ragmc_pkg::COL_W'(1);
                    if (walk_col_reg == ragmc_pkg::COL_W'(ragmc_pkg::MAX_COLS - 1)) begin
                        walk_col_next = '0;
                        walk_row_next = walk_row_reg + ragmc_pkg::ROW_W'(1);
                    end
                    if (walk_last) begin
                        state_next = ragmc_pkg::ST_W_OUT;
                    end
                end
            end
            ragmc_pkg::ST_W_SUM: begin
                rowacc_next = add_sum;
                state_next  = ragmc_pkg::ST_W_COL;
            end
            ragmc_pkg::ST_W_COL: begin
                val_next   = add_sum;
                col_we     = 1'b1;
                state_next = ragmc_pkg::ST_W_CMP;
            end
            ragmc_pkg::ST_W_CMP: begin
                if (first_reg || ($signed(val_reg) > $signed(best_reg))) begin
                    best_next  = val_reg;
                    count_next = ragmc_pkg::COUNT_W'(1);
                    first_next = 1'b0;
                end else if (val_reg == best_reg) begin
                    count_next = count_reg + ragmc_pkg::COUNT_W'(1);
                end
                walk_col_next = walk_col_reg + ragmc_pkg::COL_W'(1);
                if (walk_col_reg == ragmc_pkg::COL_W'(ragmc_pkg::MAX_COLS - 1)) begin
                    walk_col_next = '0;
                    walk_row_next = walk_row_reg + ragmc_pkg::ROW_W'(1);
                end
                state_next = walk_last ? ragmc_pkg::ST_W_OUT : ragmc_pkg::ST_W_RD;
            end
            ragmc_pkg::ST_W_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_value_next = best_reg;
                    out_count_next = ragmc_pkg::OCOUNT_W'(count_reg);
                    m_valid_next   = 1'b1;
                    state_next     = ragmc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ragmc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ragmc_pkg::ST_CLEAR;
            phase_reg     <= '0;
            walk_row_reg  <= '0;
            walk_col_reg  <= '0;
            m_valid_reg   <= 1'b0;
            grid_rows_reg <= ragmc_pkg::clamp_size(7'd64, ragmc_pkg::MAX_ROWS);
            grid_cols_reg <= ragmc_pkg::clamp_size(7'd64, ragmc_pkg::MAX_COLS);
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            walk_row_reg <= walk_row_next;
            walk_col_reg <= walk_col_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == ragmc_pkg::CFG_GRID_ROWS) begin
                    grid_rows_reg <= ragmc_pkg::clamp_size(cfg_data, ragmc_pkg::MAX_ROWS);
                end else if (cfg_index == ragmc_pkg::CFG_GRID_COLS) begin
                    grid_cols_reg <= ragmc_pkg::clamp_size(cfg_data, ragmc_pkg::MAX_COLS);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            r1_reg  <= s_row_first;
            c1_reg  <= s_col_first;
            r2_reg  <= s_row_last;
            c2_reg  <= s_col_last;
            amt_reg <= s_amount;
        end
        wr_addr_reg   <= wr_addr_next;
        wr_neg_reg    <= wr_neg_next;
        wr_keep_reg   <= wr_keep_next;
        rowacc_reg    <= rowacc_next;
        val_reg       <= val_next;
        best_reg      <= best_next;
        count_reg     <= count_next;
        first_reg     <= first_next;
        out_value_reg <= out_value_next;
        out_count_reg <= out_count_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            grid_mem[mem_wa] <= mem_wd;
        end
        grid_rd_reg <= grid_mem[mem_ra];
    end

    always_ff @(posedge aclk) begin
        if (col_we) begin
            col_mem[walk_col_reg] <= add_sum;
        end
        col_rd_reg <= col_mem[walk_col_reg];
    end

`ifndef SYNTH
    // the grid is only written by the clearing pass, the walk and corner updates
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ragmc_pkg::ST_CLEAR || state_reg == ragmc_pkg::ST_ADD
                    || state_reg == ragmc_pkg::ST_W_RD))
        else $error("grid write outside clear, add or walk read");

    // no corner write before the first corner has been read
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ragmc_pkg::ST_ADD && phase_reg == '0) |-> !mem_we)
        else $error("corner write without a pending read");

    // a result word only appears at the end of a walk
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ragmc_pkg::ST_W_OUT))
        else $error("result word not from a finished walk");

    // a reported maximum is held by at least one cell
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_count_reg != '0))
        else $error("result word with zero count");
`endif

endmodule
